// ===== design/i2c_trb_pkg.sv =====
// Shared types and command/response codes for the I2C target register bank.
package i2c_trb_pkg;

   typedef logic [3:0] cmd_type;
   typedef logic [1:0] resp_type;
   typedef logic [7:0] byte_type;

   // Bus event and local access codes
   localparam cmd_type CMD_READ_ADDR   = 4'd0;
   localparam cmd_type CMD_MASTER_ACK  = 4'd1;
   localparam cmd_type CMD_WRITE_ADDR  = 4'd2;
   localparam cmd_type CMD_BYTE_ACK    = 4'd3;
   localparam cmd_type CMD_BYTE_NACK   = 4'd4;
   localparam cmd_type CMD_BUS_ERROR   = 4'd5;
   localparam cmd_type CMD_OTHER       = 4'd6;
   localparam cmd_type CMD_LOCAL_READ  = 4'd7;
   localparam cmd_type CMD_LOCAL_WRITE = 4'd8;

   // Bus responses
   localparam resp_type RESP_ACK  = 2'd0;
   localparam resp_type RESP_NACK = 2'd1;
   localparam resp_type RESP_STOP = 2'd2;
   localparam resp_type RESP_NONE = 2'd3;

   localparam byte_type OOR_READ_VALUE = 8'hFF;

   // One write port request into the register store
   typedef struct packed {
      logic     en;
      byte_type addr;
      byte_type data;
   } mem_wr_type;

endpackage

// ===== design/i2c_trb_store.sv =====
// Register store: synchronous byte memory with per-entry valid bits and range checks.
module i2c_trb_store #(
   parameter int REGISTER_COUNT = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  i2c_trb_pkg::mem_wr_type wr,
   input  logic                    rd_en,
   input  i2c_trb_pkg::byte_type   rd_addr,
   output i2c_trb_pkg::byte_type   rd_data
);
   import i2c_trb_pkg::*;

   localparam int IDX_W = $clog2(REGISTER_COUNT);
   localparam logic [8:0] COUNT_LIM = 9'(REGISTER_COUNT);

   byte_type                  mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;
   byte_type                  rdata_ff;
   logic                      hit_ff;
   logic                      oor_ff;

   logic             wr_ok;
   logic             rd_ok;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   assign wr_ok  = ({1'b0, wr.addr} < COUNT_LIM);
   assign rd_ok  = ({1'b0, rd_addr} < COUNT_LIM);
   assign wr_idx = wr.addr[IDX_W-1:0];
   assign rd_idx = rd_addr[IDX_W-1:0];

   // Memory array, no reset; valid bits stand in for the cleared contents
   always_ff @(posedge clock) begin
      if (wr.en && wr_ok) begin
         mem[wr_idx] <= wr.data;
      end
      if (rd_en && rd_ok) begin
         rdata_ff <= mem[rd_idx];
      end
      if (rd_en) begin
         hit_ff <= rd_ok && valid_ff[rd_idx];
         oor_ff <= !rd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr_ok) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      if (oor_ff) begin
         rd_data = OOR_READ_VALUE;
      end else if (hit_ff) begin
         rd_data = rdata_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== design/i2c_target_register_bank_unit.sv =====
// Top level of the I2C target register bank: command decode, pointer state, result strobe.
//
// A command is accepted at an edge where start is high and busy is low; busy is then
// high for one cycle while the register store's synchronous read completes, and the
// result appears on the rsp_ ports with rsp_strobe high for exactly one cycle, the
// cycle right after busy. busy is low in that strobe cycle, so the next command can be
// accepted at its closing edge; no command is accepted while busy is high. Every
// command produces exactly one result and the receiver cannot stall it, so results
// must be captured on the strobe. The store reads as all zeros after reset (per-entry
// valid bits, no clearing pass). A read of an index at or beyond REGISTER_COUNT gives
// 0xFF; writes there are dropped.
module i2c_target_register_bank_unit #(
   parameter int REGISTER_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  i2c_trb_pkg::cmd_type  req_command,
   input  i2c_trb_pkg::byte_type req_bus_data,
   input  i2c_trb_pkg::byte_type req_local_address,
   input  i2c_trb_pkg::byte_type req_local_data,
   // result channel
   output logic                  rsp_strobe,
   output i2c_trb_pkg::byte_type rsp_transmit_byte,
   output i2c_trb_pkg::resp_type rsp_bus_response,
   output i2c_trb_pkg::byte_type rsp_local_read_data
);
   import i2c_trb_pkg::*;

   localparam logic [8:0] COUNT_LIM = 9'(REGISTER_COUNT);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   // where the read data goes in the result
   localparam logic [1:0] SEL_NONE  = 2'd0;
   localparam logic [1:0] SEL_TX    = 2'd1;
   localparam logic [1:0] SEL_LOCAL = 2'd2;

   logic       state_ff, state_in;
   byte_type   pointer_ff, pointer_in;
   logic       loaded_ff, loaded_in;
   resp_type   resp_ff, resp_in;
   logic [1:0] sel_ff, sel_in;

   logic     strobe_ff;
   byte_type tx_ff;
   resp_type bus_resp_ff;
   byte_type lrd_ff;

   logic       accept;
   logic [8:0] ptr_next;
   mem_wr_type wr;
   logic       rd_en;
   byte_type   rd_addr;
   byte_type   rd_data;

   assign busy     = (state_ff == ST_READ);
   assign accept   = start && !busy;
   assign ptr_next = {1'b0, pointer_ff} + 9'd1;

   i2c_trb_store #(
      .REGISTER_COUNT(REGISTER_COUNT)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Command decode. Writes land in the store at the accept edge, reads are
   // launched there and picked up in the busy cycle after it.
   always_comb begin
      state_in   = ST_IDLE;
      pointer_in = pointer_ff;
      loaded_in  = loaded_ff;
      resp_in    = resp_ff;
      sel_in     = sel_ff;
      wr         = '0;
      rd_en      = 1'b0;
      rd_addr    = pointer_ff;
      if (accept) begin
         state_in = ST_READ;
         sel_in   = SEL_NONE;
         unique case (req_command)
            CMD_READ_ADDR: begin
               rd_en   = 1'b1;
               sel_in  = SEL_TX;
               resp_in = RESP_ACK;
            end
            CMD_MASTER_ACK: begin
               // pre-increment; stop at the last register with a nack
               if (ptr_next < COUNT_LIM) begin
                  pointer_in = ptr_next[7:0];
                  rd_en      = 1'b1;
                  rd_addr    = ptr_next[7:0];
                  sel_in     = SEL_TX;
                  resp_in    = RESP_ACK;
               end else begin
                  resp_in = RESP_NACK;
               end
            end
            CMD_WRITE_ADDR: begin
               loaded_in = 1'b0;
               resp_in   = RESP_ACK;
            end
            CMD_BYTE_ACK: begin
               // first byte of a write transfer is the pointer
               if (!loaded_ff) begin
                  pointer_in = req_bus_data;
                  loaded_in  = 1'b1;
               end else begin
                  wr.en   = 1'b1;
                  wr.addr = pointer_ff;
                  wr.data = req_bus_data;
               end
               resp_in = RESP_ACK;
            end
            CMD_BYTE_NACK: begin
               wr.en   = 1'b1;
               wr.addr = pointer_ff;
               wr.data = req_bus_data;
               resp_in = RESP_NONE;
            end
            CMD_BUS_ERROR: begin
               resp_in = RESP_STOP;
            end
            CMD_LOCAL_READ: begin
               rd_en   = 1'b1;
               rd_addr = req_local_address;
               sel_in  = SEL_LOCAL;
               resp_in = RESP_NONE;
            end
            CMD_LOCAL_WRITE: begin
               wr.en   = 1'b1;
               wr.addr = req_local_address;
               wr.data = req_local_data;
               resp_in = RESP_NONE;
            end
            default: begin
               // CMD_OTHER and unused codes
               resp_in = RESP_NACK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pointer_ff <= '0;
         loaded_ff  <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pointer_ff <= pointer_in;
         loaded_ff  <= loaded_in;
         strobe_ff  <= busy;
      end
   end

   // pending transaction info and result registers (payload, no reset)
   always_ff @(posedge clock) begin
      resp_ff <= resp_in;
      sel_ff  <= sel_in;
      if (busy) begin
         tx_ff       <= (sel_ff == SEL_TX) ? rd_data : '0;
         lrd_ff      <= (sel_ff == SEL_LOCAL) ? rd_data : '0;
         bus_resp_ff <= resp_ff;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_transmit_byte   = tx_ff;
   assign rsp_bus_response    = bus_resp_ff;
   assign rsp_local_read_data = lrd_ff;

   // busy lasts exactly one cycle and is always followed by a result
   a_busy_then_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe))
      else $error("busy did not end in a result strobe");

   // every accepted command raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start the read cycle");

   // a strobe only follows a busy cycle
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a pending transaction");

   // transmit byte is zero unless the bus is acknowledged
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bus_response != RESP_ACK) |-> (rsp_transmit_byte == '0))
      else $error("transmit byte set without acknowledge");

   // a pointer change only happens on an accepted command
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> $stable(pointer_ff))
      else $error("pointer moved without a command");

endmodule
